>>> rtl/core/nv21_pair_to_rgb_top_macros.svh
// Assertion macros shared by the NV21 pair to RGB converter.
`ifndef NV21_PAIR_TO_RGB_TOP_MACROS_SVH
`define NV21_PAIR_TO_RGB_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define N2R_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("n2r assertion failed");
`define N2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("n2r assertion failed");
`else
`define N2R_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define N2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/n2r_pkg.sv
// Shared types, constants and colour conversion function for the NV21 to RGB converter.
package n2r_pkg;

    localparam int QueueDepth = 2;
    localparam int FracBits   = 7;

    localparam logic signed [17:0] ChromaBias = 18'sd128;
    localparam logic signed [17:0] CoefRV     = 18'sd176;
    localparam logic signed [17:0] CoefGV     = 18'sd89;
    localparam logic signed [17:0] CoefGU     = 18'sd43;
    localparam logic signed [17:0] CoefBU     = 18'sd222;
    localparam logic [7:0]         ClipMax    = 8'hFF;

    // One pair of pixels with every chroma byte its two pixels need
    typedef struct packed {
        logic [7:0] y_even;
        logic [7:0] y_odd;
        logic [7:0] u_own;
        logic [7:0] u_next;
        logic [7:0] v_own;
        logic [7:0] v_prev;
        logic       row_end;
        logic       last;
    } t_pair_job;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic logic [7:0] clip_shift(input logic signed [17:0] t);
        logic [7:0] res;
        if (t < 0) begin
            res = 8'd0;
        end else if (t[17:FracBits] > 11'(ClipMax)) begin
            res = ClipMax;
        end else begin
            res = t[FracBits+7:FracBits];
        end
        return res;
    endfunction

    function automatic t_rgb yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                        input logic [7:0] v);
        logic signed [17:0] ys;
        logic signed [17:0] du;
        logic signed [17:0] dv;
        t_rgb               res;
        ys = signed'({3'b000, y, 7'b0000000});
        du = signed'({10'd0, u}) - ChromaBias;
        dv = signed'({10'd0, v}) - ChromaBias;
        res.red   = clip_shift(ys + CoefRV * dv);
        res.green = clip_shift(ys - CoefGV * dv - CoefGU * du);
        res.blue  = clip_shift(ys + CoefBU * du);
        return res;
    endfunction

endpackage

>>> rtl/core/nv21_pair_to_rgb_top.sv
// Top level of the NV21 pixel pair to RGB converter.
// A released pair is queued, then each pixel passes the averaging and output registers.
// Throughput: one pixel per cycle at the output while i_ready stays high and jobs are queued.
// A row-ending transfer behind a held pair takes two job pushes in the front, held pair first.
// Reset (synchronous, active low) empties the job queue, the pixel stages and the held pair.
module nv21_pair_to_rgb_top #(
    parameter int QUEUE_DEPTH = n2r_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_luma_even,
    input  logic [7:0] i_luma_odd,
    input  logic [7:0] i_chroma_v,
    input  logic [7:0] i_chroma_u,
    input  logic       i_row_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_row_end,
    output logic       o_last_of_run
);
    import n2r_pkg::*;

    // Front to queue: push a pair job whenever a pair is complete enough to convert
    logic      push;
    t_pair_job push_job;
    logic      full;

    // Queue to back: the oldest job, dropped once both its pixels have advanced
    logic      head_valid;
    t_pair_job head_job;
    logic      pop;

    n2r_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_luma_even (i_luma_even),
        .i_luma_odd  (i_luma_odd),
        .i_chroma_v  (i_chroma_v),
        .i_chroma_u  (i_chroma_u),
        .i_row_last  (i_row_last),
        .o_push      (push),
        .o_push_job  (push_job),
        .i_full      (full)
    );

    // Decouple the two sides so a stalled output does not freeze the input at once
    n2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_job   (head_job)
    );

    // Two registered stages: chroma averaging, then colour matrix and clipping
    n2r_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head_job    (head_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_row_end     (o_row_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> rtl/core/n2r_queue.sv
// Small FIFO of pair jobs between the front and back parts.
`include "nv21_pair_to_rgb_top_macros.svh"
module n2r_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  n2r_pkg::t_pair_job  i_push_job,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_head_valid,
    output n2r_pkg::t_pair_job  o_head_job
);
    import n2r_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_pair_job       r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;

    assign o_full       = (r_count == CntW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    `N2R_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(DEPTH))
    `N2R_ASSERT_IMPL(a_queue_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop)

endmodule

>>> rtl/core/n2r_front.sv
// Front part: accepts pixel pairs, holds one back and issues pair jobs.
`include "nv21_pair_to_rgb_top_macros.svh"
module n2r_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_luma_even,
    input  logic [7:0]          i_luma_odd,
    input  logic [7:0]          i_chroma_v,
    input  logic [7:0]          i_chroma_u,
    input  logic                i_row_last,
    output logic                o_push,
    output n2r_pkg::t_pair_job  o_push_job,
    input  logic                i_full
);
    import n2r_pkg::*;

    logic       r_held_valid, n_held_valid;
    logic       r_phase,      n_phase;
    logic [7:0] r_held_ye;
    logic [7:0] r_held_yo;
    logic [7:0] r_held_v;
    logic [7:0] r_held_u;
    logic [7:0] r_prior_v;

    logic need_push;
    logic two_push;
    logic sel_own;
    logic accept;
    logic [7:0] own_vp;

    assign need_push = r_held_valid || i_row_last;
    assign two_push  = r_held_valid && i_row_last;
    // the held pair goes first; the item's own pair only when it ends the row
    assign sel_own   = r_phase || !r_held_valid;
    assign own_vp    = r_held_valid ? r_held_v : i_chroma_v;

    assign o_ready = !need_push || (!i_full && (!two_push || r_phase));
    assign accept  = i_valid && o_ready;
    assign o_push  = i_valid && need_push && !i_full;

    always_comb begin
        if (sel_own) begin
            o_push_job = '{y_even: i_luma_even, y_odd: i_luma_odd, u_own: i_chroma_u,
                           u_next: i_chroma_u, v_own: i_chroma_v, v_prev: own_vp,
                           row_end: 1'b1, last: 1'b1};
        end else begin
            o_push_job = '{y_even: r_held_ye, y_odd: r_held_yo, u_own: r_held_u,
                           u_next: i_chroma_u, v_own: r_held_v, v_prev: r_prior_v,
                           row_end: 1'b0, last: !i_row_last};
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_held_valid = r_held_valid;
        if (accept) begin
            n_phase      = 1'b0;
            n_held_valid = !i_row_last;
        end else if (o_push && two_push) begin
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_phase      <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_phase      <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_row_last) begin
            r_held_ye <= i_luma_even;
            r_held_yo <= i_luma_odd;
            r_held_v  <= i_chroma_v;
            r_held_u  <= i_chroma_u;
            r_prior_v <= own_vp;
        end
    end

    `N2R_ASSERT_IMPL(a_phase_ctx, i_clk, i_rst_n, r_phase,
                     i_valid && r_held_valid && i_row_last)
    `N2R_ASSERT_NEXT(a_phase_follows, i_clk, i_rst_n,
                     o_push && two_push && !r_phase, r_phase)

endmodule

>>> rtl/core/n2r_back.sv
// Back part: splits pair jobs into pixels and converts them to RGB.
`include "nv21_pair_to_rgb_top_macros.svh"
module n2r_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  n2r_pkg::t_pair_job  i_head_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic                o_row_end,
    output logic                o_last_of_run
);
    import n2r_pkg::*;

    logic       r_sub;
    logic       r_a_valid;
    logic [7:0] r_a_y, r_a_u, r_a_v;
    logic       r_a_row_end, r_a_last;
    logic       r_o_valid;
    t_rgb       r_o_rgb;
    logic       r_o_row_end, r_o_last;

    logic       adv_o, adv_a;
    logic [8:0] v_sum, u_sum;
    logic [7:0] n_a_y, n_a_u, n_a_v;
    logic       n_a_row_end, n_a_last;

    assign adv_o = !r_o_valid || i_ready;
    assign adv_a = !r_a_valid || adv_o;
    assign o_pop = adv_a && i_head_valid && r_sub;

    assign v_sum = {1'b0, i_head_job.v_own} + {1'b0, i_head_job.v_prev};
    assign u_sum = {1'b0, i_head_job.u_next} + {1'b0, i_head_job.u_own};

    // left pixel: own U, averaged V; right pixel: averaged U, own V
    always_comb begin
        if (!r_sub) begin
            n_a_y       = i_head_job.y_even;
            n_a_u       = i_head_job.u_own;
            n_a_v       = v_sum[8:1];
            n_a_row_end = 1'b0;
            n_a_last    = 1'b0;
        end else begin
            n_a_y       = i_head_job.y_odd;
            n_a_u       = u_sum[8:1];
            n_a_v       = i_head_job.v_own;
            n_a_row_end = i_head_job.row_end;
            n_a_last    = i_head_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub     <= 1'b0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_valid <= i_head_valid;
                if (i_head_valid) begin
                    r_sub <= !r_sub;
                end
            end
            if (adv_o) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_head_valid) begin
            r_a_y       <= n_a_y;
            r_a_u       <= n_a_u;
            r_a_v       <= n_a_v;
            r_a_row_end <= n_a_row_end;
            r_a_last    <= n_a_last;
        end
        if (adv_o && r_a_valid) begin
            r_o_rgb     <= yuv_to_rgb(r_a_y, r_a_u, r_a_v);
            r_o_row_end <= r_a_row_end;
            r_o_last    <= r_a_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_red         = r_o_rgb.red;
    assign o_green       = r_o_rgb.green;
    assign o_blue        = r_o_rgb.blue;
    assign o_row_end     = r_o_row_end;
    assign o_last_of_run = r_o_last;

    `N2R_ASSERT_IMPL(a_sub_head, i_clk, i_rst_n, r_sub, i_head_valid)

endmodule

>>> tb/n2r_pixel_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the converter's RGB pixel stream.
module n2r_pixel_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pair_valid,
    input  logic       i_pair_ready,
    input  logic [7:0] i_luma_even,
    input  logic [7:0] i_luma_odd,
    input  logic [7:0] i_chroma_v,
    input  logic [7:0] i_chroma_u,
    input  logic       i_row_last,
    input  logic       i_pix_valid,
    input  logic       i_pix_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_row_end,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_outstanding
);

    localparam int Bias   = 128;
    localparam int CoefRV = 176;
    localparam int CoefGV = 89;
    localparam int CoefGU = 43;
    localparam int CoefBU = 222;
    localparam int Frac   = 7;
    localparam int Top    = 255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       last;
    } t_pixel;

    t_pixel     pending_pixels[$];
    logic [7:0] kept_luma_even;
    logic [7:0] kept_luma_odd;
    logic [7:0] kept_v;
    logic [7:0] kept_u;
    logic [7:0] kept_prev_v;
    logic       kept_valid;
    int         fail_count;
    int         pixel_index;

    function automatic logic [7:0] clamp_scaled(input int t);
        int s;
        if (t < 0) return 8'd0;
        s = t >>> Frac;
        if (s > Top) return 8'd255;
        return s[7:0];
    endfunction

    function automatic t_pixel convert_pixel(input logic [7:0] y, input logic [7:0] u,
                                             input logic [7:0] v, input logic row_end,
                                             input logic last);
        int     ys;
        int     du;
        int     dv;
        t_pixel px;
        ys = Bias * int'(y);
        du = int'(u) - Bias;
        dv = int'(v) - Bias;
        px.red     = clamp_scaled(ys + CoefRV * dv);
        px.green   = clamp_scaled(ys - CoefGV * dv - CoefGU * du);
        px.blue    = clamp_scaled(ys + CoefBU * du);
        px.row_end = row_end;
        px.last    = last;
        return px;
    endfunction

    // Left pixel takes the averaged V, right pixel the averaged U.
    function automatic void queue_pair(input logic [7:0] ye, input logic [7:0] yo,
                                       input logic [7:0] u_own, input logic [7:0] u_next,
                                       input logic [7:0] v_own, input logic [7:0] v_prev,
                                       input logic ends_row, input logic last);
        logic [8:0] v_avg;
        logic [8:0] u_avg;
        v_avg = ({1'b0, v_own} + {1'b0, v_prev}) >> 1;
        u_avg = ({1'b0, u_own} + {1'b0, u_next}) >> 1;
        pending_pixels.push_back(convert_pixel(ye, u_own, v_avg[7:0], 1'b0, 1'b0));
        pending_pixels.push_back(convert_pixel(yo, u_avg[7:0], v_own, ends_row, last));
    endfunction

    function automatic void take_pair(input logic [7:0] ye, input logic [7:0] yo,
                                      input logic [7:0] v, input logic [7:0] u,
                                      input logic ends_row);
        logic [7:0] v_before;
        if (kept_valid) begin
            queue_pair(kept_luma_even, kept_luma_odd, kept_u, u, kept_v, kept_prev_v,
                       1'b0, !ends_row);
            v_before = kept_v;
        end else begin
            v_before = v;
        end
        if (ends_row) begin
            queue_pair(ye, yo, u, u, v, v_before, 1'b1, 1'b1);
            kept_valid = 1'b0;
        end else begin
            kept_luma_even = ye;
            kept_luma_odd  = yo;
            kept_v         = v;
            kept_u         = u;
            kept_prev_v    = v_before;
            kept_valid     = 1'b1;
        end
    endfunction

    task automatic report_fault(input string msg);
        $display("%0t pixel %0d: %s", $time, pixel_index, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            pending_pixels.delete();
            kept_luma_even = 8'd0;
            kept_luma_odd  = 8'd0;
            kept_v         = 8'd0;
            kept_u         = 8'd0;
            kept_prev_v    = 8'd0;
            kept_valid     = 1'b0;
        end else begin
            if (i_pair_valid && i_pair_ready) begin
                take_pair(i_luma_even, i_luma_odd, i_chroma_v, i_chroma_u, i_row_last);
            end
            if (i_pix_valid && i_pix_ready) begin
                got = '{i_red, i_green, i_blue, i_row_end, i_last_of_run};
                if (pending_pixels.size() == 0) begin
                    report_fault("pixel arrived with none expected");
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red)
                        report_fault($sformatf("red %0d, expected %0d", got.red, want.red));
                    if (got.green !== want.green)
                        report_fault($sformatf("green %0d, expected %0d",
                                               got.green, want.green));
                    if (got.blue !== want.blue)
                        report_fault($sformatf("blue %0d, expected %0d", got.blue, want.blue));
                    if (got.row_end !== want.row_end)
                        report_fault($sformatf("row_end %0b, expected %0b",
                                               got.row_end, want.row_end));
                    if (got.last !== want.last)
                        report_fault($sformatf("last_of_run %0b, expected %0b",
                                               got.last, want.last));
                end
                pixel_index++;
            end
        end
        o_outstanding <= pending_pixels.size();
        o_fail_count  <= fail_count;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the NV21 pair to RGB converter testbench: stimulus, pixel sink and verdict.
module testbench;

    localparam int MaxGap       = 5;
    localparam int RandomPairs  = 313;
    localparam int DrainCycles  = 12;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_luma_even;
    logic [7:0] i_luma_odd;
    logic [7:0] i_chroma_v;
    logic [7:0] i_chroma_u;
    logic       i_row_last;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic       o_row_end;
    logic       o_last_of_run;

    int   fail_count;
    int   outstanding;
    int   pairs_sent;
    logic steady;

    nv21_pair_to_rgb_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_luma_even  (i_luma_even),
        .i_luma_odd   (i_luma_odd),
        .i_chroma_v   (i_chroma_v),
        .i_chroma_u   (i_chroma_u),
        .i_row_last   (i_row_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_row_end    (o_row_end),
        .o_last_of_run(o_last_of_run)
    );

    n2r_pixel_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (i_valid),
        .i_pair_ready (o_ready),
        .i_luma_even  (i_luma_even),
        .i_luma_odd   (i_luma_odd),
        .i_chroma_v   (i_chroma_v),
        .i_chroma_u   (i_chroma_u),
        .i_row_last   (i_row_last),
        .i_pix_valid  (o_valid),
        .i_pix_ready  (i_ready),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .i_row_end    (o_row_end),
        .i_last_of_run(o_last_of_run),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Favour the byte extremes so that every clip path and carry gets exercised.
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one pair and hold it until the converter takes it. Drop valid for the
    // drawn gap first, unless a steady stretch is running; with no gap keep valid
    // high straight through, so back-to-back transfers need no second assignment.
    task automatic send_pair(input logic [7:0] ye, input logic [7:0] yo,
                             input logic [7:0] v, input logic [7:0] u,
                             input logic ends_row);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_luma_even <= ye;
        i_luma_odd  <= yo;
        i_chroma_v  <= v;
        i_chroma_u  <= u;
        i_row_last  <= ends_row;
        do @(posedge i_clk); while (!o_ready);
        pairs_sent++;
    endtask

    // A well-formed row: random pairs, the last one flagged as the row end.
    task automatic send_row(input int len);
        for (int k = 0; k < len; k++) begin
            send_pair(rand_byte(), rand_byte(), rand_byte(), rand_byte(), k == len - 1);
        end
    endtask

    // Pixel sink: stall for a drawn number of cycles before each transfer, or
    // take pixels at full rate while a steady stretch runs.
    initial begin : pixel_sink
        int stall;
        i_ready <= 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, MaxGap);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int len;
        pairs_sent  = 0;
        steady      <= 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_luma_even <= 8'd0;
        i_luma_odd  <= 8'd0;
        i_chroma_v  <= 8'd0;
        i_chroma_u  <= 8'd0;
        i_row_last  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-pair rows: emitted at once with their own U and V, at the extremes and at mid-scale.
        send_pair(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        send_pair(8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
        send_pair(8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
        // Three-pair row: a held pair released by a normal pair, then by the row end.
        send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pair(8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
        // Two-pair row: the row end also flushes the held pair, four pixels in one go.
        send_pair(8'd16, 8'd235, 8'd128, 8'd128, 1'b0);
        send_pair(8'd235, 8'd16, 8'd0, 8'd255, 1'b1);
        // Longer row swinging between opposite chroma extremes to saturate every channel.
        send_pair(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        send_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
        send_pair(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
        send_pair(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
        send_pair(8'd170, 8'd85, 8'd1, 8'd254, 1'b1);
        // An odd V sum at the row end, so its average rounds down.
        send_pair(8'd85, 8'd170, 8'd254, 8'd1, 1'b0);
        send_pair(8'd255, 8'd255, 8'd127, 8'd129, 1'b1);
        // Held pair left waiting across a long idle stretch before its successor.
        send_pair(8'd200, 8'd50, 8'd60, 8'd190, 1'b0);
        i_valid <= 1'b0;
        repeat (30) @(posedge i_clk);
        send_pair(8'd50, 8'd200, 8'd190, 8'd60, 1'b1);

        // Random rows: mostly short, a few long ones, with steady stretches where
        // neither side idles.
        while (pairs_sent < RandomPairs + 17) begin
            if ($urandom_range(0, 5) == 0) steady <= !steady;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
            send_row(len);
        end
        steady  <= 1'b0;
        i_valid <= 1'b0;

        // Drain: wait for every expected pixel, then linger for stray extras.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS nv21_pair_to_rgb_top");
        end else begin
            $display("FAIL nv21_pair_to_rgb_top");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL nv21_pair_to_rgb_top");
        $finish;
    end

endmodule

>>> nv21_pair_to_rgb_top.f
+incdir+rtl/core
rtl/core/n2r_pkg.sv
rtl/core/n2r_queue.sv
rtl/core/n2r_front.sv
rtl/core/n2r_back.sv
rtl/core/nv21_pair_to_rgb_top.sv
tb/n2r_pixel_checker.sv
tb/testbench.sv
